/* src/tsm_pkg.sv */
// Package for the triangular point smoother.
// Holds the coordinate width, the item structs and the controller state type.
// No dependencies; tsm_cell and the top level in src use it, tsm_div does not.
package tsm_pkg;

	// Width of one coordinate
	localparam int COORD_BITS = 10;

	typedef logic [COORD_BITS-1:0] coord_t;

	// One stored point inside the window chain
	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// Input item
	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   set_end;
	} in_item_t;

	// Result item
	typedef struct packed {
		coord_t smooth_x;
		coord_t smooth_y;
		logic   is_last;
	} out_item_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV_GO,
		ST_DIV,
		ST_HOLD
	} tsm_state_t;

endpackage

/* src/tsm_cell.sv */
// One cell of the window chain: holds one point and passes it on.
// Depends on tsm_pkg for the point type.
module tsm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  tsm_pkg::point_t d,
	output tsm_pkg::point_t q
);

	tsm_pkg::point_t pt_q;

	// Take the neighbor's point on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= '0;
		end else if (shift) begin
			pt_q <= d;
		end
	end

	assign q = pt_q;

endmodule

/* src/tsm_div.sv */
// Restoring divider, one quotient bit per cycle, for one coordinate lane.
// Depends on no package; widths come from parameters set by the top level.
module tsm_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 8,
	parameter int QB    = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QB-1:0]    quot
);

	localparam int CNT_W = $clog2(QB + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QB-1:0]    low_q;
	logic [QB-1:0]    quot_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, low_q[QB-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// Control: count the quotient bits, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the upper numerator bits, then shift one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DEN_W'(num >> QB);
			low_q  <= num[QB-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q  <= {low_q[QB-2:0], 1'b0};
			quot_q <= {quot_q[QB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* src/triangular_point_smoother.sv */
// Triangular point smoother, top level: window chain, tail accumulator, two dividers.
// Flow: an item that gives a result takes one ring rotation of the 2*MAX_HALF+1 cells (ST_ACC),
//   a divider start (ST_DIV_GO) and the division at one divider bit per cycle (ST_DIV), then
//   waits in ST_HOLD while the output register is still full; no new item is taken meanwhile.
// An item that gives no result leaves the block ready for the next item at once.
// Reset: arst_n clears history, fill count and handshake state; kernel_half returns to 1.
module triangular_point_smoother #(
	parameter int MAX_HALF = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsm_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tsm_pkg::out_item_t  out_item
);

	localparam int CB     = tsm_pkg::COORD_BITS;
	localparam int NCELL  = 2 * MAX_HALF + 1;
	localparam int HE     = (MAX_HALF < 7) ? MAX_HALF : 7;
	localparam int DMAX   = (HE + 1) * (HE + 1);
	localparam int SUM_W  = CB + $clog2(DMAX + 1);
	localparam int NUM_W  = SUM_W + 1;
	localparam int DEN_W  = $clog2(2 * DMAX + 1);
	localparam int WW     = $clog2(HE + 2);
	localparam int KW     = $clog2(NCELL);
	localparam int FW     = $clog2(2 * MAX_HALF + 1);
	localparam int CW     = (FW > 4) ? FW : 4;

	tsm_pkg::tsm_state_t state_q, state_d;

	logic [2:0]       kernel_half_q;
	logic [2:0]       h_eff;
	logic [2:0]       h_q;
	logic [FW-1:0]    fill_q;
	logic             last_q;
	logic [KW-1:0]    k_q;
	logic [SUM_W-1:0] acc_x_q;
	logic [SUM_W-1:0] acc_y_q;
	logic             in_accept;
	logic             produce;
	logic             rotate;
	logic             div_start;
	logic             load_out;
	logic             out_free;
	logic             out_valid_q;
	tsm_pkg::out_item_t out_q;

	tsm_pkg::point_t  chain [NCELL];
	tsm_pkg::point_t  head;

	logic [KW-1:0]    hk;
	logic [KW-1:0]    tap_dist;
	logic             in_win;
	logic [KW:0]      w_wide;
	logic [WW-1:0]    weight;
	logic [CB+WW-1:0] prod_x;
	logic [CB+WW-1:0] prod_y;
	logic [WW-1:0]    hp1;
	logic [DEN_W-1:0] den2;
	logic [NUM_W-1:0] num_x;
	logic [NUM_W-1:0] num_y;
	logic             done_x;
	logic             done_y;
	logic [CB-1:0]    quot_x;
	logic [CB-1:0]    quot_y;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_half_q <= 3'd1;
		end else if (cfg_we) begin
			kernel_half_q <= cfg_wdata;
		end
	end

	// Clamp the half width to the chain length
	assign h_eff = ({1'b0, kernel_half_q} > 4'(MAX_HALF)) ? 3'(MAX_HALF) : kernel_half_q;

	assign in_accept = in_valid && in_ready;
	assign produce   = CW'(fill_q) >= CW'({h_eff, 1'b0});
	assign out_free  = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsm_pkg::ST_IDLE: begin
				if (in_accept && produce) state_d = tsm_pkg::ST_ACC;
			end
			tsm_pkg::ST_ACC: begin
				if (k_q == '0) state_d = tsm_pkg::ST_DIV_GO;
			end
			tsm_pkg::ST_DIV_GO: begin
				state_d = tsm_pkg::ST_DIV;
			end
			tsm_pkg::ST_DIV: begin
				if (done_x) state_d = out_free ? tsm_pkg::ST_IDLE : tsm_pkg::ST_HOLD;
			end
			tsm_pkg::ST_HOLD: begin
				if (out_free) state_d = tsm_pkg::ST_IDLE;
			end
			default: state_d = tsm_pkg::ST_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_ready  = 1'b0;
		rotate    = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			tsm_pkg::ST_IDLE:   in_ready  = 1'b1;
			tsm_pkg::ST_ACC:    rotate    = 1'b1;
			tsm_pkg::ST_DIV_GO: div_start = 1'b1;
			tsm_pkg::ST_DIV:    load_out  = done_x && out_free;
			tsm_pkg::ST_HOLD:   load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count: restart after each set, saturate at the history depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_accept) begin
			if (in_item.set_end) begin
				fill_q <= '0;
			end else if (fill_q < FW'(2 * MAX_HALF)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Capture per-item context; walk the tap index down during the rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (in_accept) begin
			k_q <= KW'(NCELL - 1);
		end else if (rotate) begin
			k_q <= k_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			h_q    <= h_eff;
			last_q <= in_item.set_end;
		end
	end

	// Window chain: shift in the new point, or close the ring while accumulating
	assign head = in_accept ? tsm_pkg::point_t'({in_item.point_x, in_item.point_y})
	                        : chain[NCELL-1];

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		tsm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (in_accept || rotate),
			.d      ((i == 0) ? head : chain[(i == 0) ? 0 : i-1]),
			.q      (chain[i])
		);
	end

	// Triangular weight of the tap now at the tail of the chain
	always_comb begin
		hk       = KW'(h_q);
		tap_dist = (k_q > hk) ? (k_q - hk) : (hk - k_q);
		in_win   = {1'b0, k_q} <= {hk, 1'b0};
		w_wide   = (KW+1)'(hk) + 1'b1 - (KW+1)'(tap_dist);
		weight   = in_win ? WW'(w_wide) : '0;
		prod_x   = chain[NCELL-1].x * weight;
		prod_y   = chain[NCELL-1].y * weight;
	end

	// Accumulate the weighted taps as they pass the tail
	always_ff @(posedge clk) begin
		if (in_accept) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (rotate) begin
			acc_x_q <= acc_x_q + SUM_W'(prod_x);
			acc_y_q <= acc_y_q + SUM_W'(prod_y);
		end
	end

	// Round half up: (2*S + D) / (2*D)
	always_comb begin
		hp1   = WW'(h_q) + 1'b1;
		den2  = DEN_W'({DEN_W'(hp1) * DEN_W'(hp1), 1'b0});
		num_x = {acc_x_q, 1'b0} + NUM_W'(den2 >> 1);
		num_y = {acc_y_q, 1'b0} + NUM_W'(den2 >> 1);
	end

	tsm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(CB)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (den2),
		.done   (done_x),
		.quot   (quot_x)
	);

	tsm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QB(CB)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (den2),
		.done   (done_y),
		.quot   (quot_y)
	);

	// Output register: hold the item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.smooth_x <= quot_x;
			out_q.smooth_y <= quot_y;
			out_q.is_last  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending item");

	// Both divider lanes finish together, and only while waiting on them
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done_x || done_y) |-> (done_x == done_y) && (state_q == tsm_pkg::ST_DIV))
		else $error("divider done out of step");

	// An item without a result leaves the block ready at once
	a_pass_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !produce) |=> in_ready)
		else $error("block stalled after an item without result");
`endif

endmodule

/* tb/sv/triangular_point_smoother_test.sv */
// Self-checking testbench for the triangular point smoother.
// Drives point sets at random pace, predicts each smoothed point and compares on arrival.
// Depends on tsm_pkg and triangular_point_smoother from src.
`timescale 1ns / 1ps

module triangular_point_smoother_test;

	localparam int MAX_HALF     = 7;
	localparam int HIST_DEPTH   = 2 * MAX_HALF;
	localparam int SETTLE       = 40;
	localparam int LIMIT        = 400000;
	localparam int STALL_CYCLES = 300;
	localparam int IDLE_PCT     = 17;
	localparam int PHASE_ITEMS  = 38;
	localparam tsm_pkg::coord_t COORD_MAX = '1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic [2:0] cfg_wdata = 3'd0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	tsm_pkg::in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	tsm_pkg::out_item_t out_item;

	// Points waiting for the driver, smoothed points waiting for the block
	tsm_pkg::in_item_t  pending_points[$];
	tsm_pkg::out_item_t smoothed_q[$];

	// Predictor state
	tsm_pkg::coord_t hist_x[HIST_DEPTH];
	tsm_pkg::coord_t hist_y[HIST_DEPTH];
	int unsigned seen_in_set = 0;
	int unsigned win_half = 1;

	int unsigned cycle_count = 0;
	int unsigned bad_count = 0;
	bit          in_taken = 1'b0;
	bit          steady = 1'b0;
	bit          stall_req = 1'b0;
	bit          stall_done = 1'b0;
	int unsigned hold_left = 0;

	triangular_point_smoother i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Smooth one accepted point, then advance the window and the fill count
	task automatic track_point(input tsm_pkg::in_item_t pt);
		int unsigned h, den, sx, sy, w, tap_dist, k;
		tsm_pkg::coord_t vx, vy;
		tsm_pkg::out_item_t res;
		h = (win_half > MAX_HALF) ? MAX_HALF : win_half;
		if (seen_in_set >= 2 * h) begin
			sx = 0;
			sy = 0;
			den = (h + 1) * (h + 1);
			for (k = 0; k <= 2 * h; k++) begin
				tap_dist = (k > h) ? k - h : h - k;
				w = h + 1 - tap_dist;
				vx = (k == 0) ? pt.point_x : hist_x[k - 1];
				vy = (k == 0) ? pt.point_y : hist_y[k - 1];
				sx += w * vx;
				sy += w * vy;
			end
			res.smooth_x = tsm_pkg::coord_t'((2 * sx + den) / (2 * den));
			res.smooth_y = tsm_pkg::coord_t'((2 * sy + den) / (2 * den));
			res.is_last = pt.set_end;
			smoothed_q = {smoothed_q, res};
		end
		for (k = HIST_DEPTH - 1; k > 0; k--) begin
			hist_x[k] = hist_x[k - 1];
			hist_y[k] = hist_y[k - 1];
		end
		hist_x[0] = pt.point_x;
		hist_y[0] = pt.point_y;
		if (pt.set_end)
			seen_in_set = 0;
		else if (seen_in_set < HIST_DEPTH)
			seen_in_set++;
	endtask

	// Track accepted points and check accepted smoothed points
	always @(posedge clk) begin
		tsm_pkg::out_item_t want;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken)
			track_point(in_item);
		if (arst_n && out_valid && out_ready) begin
			if (smoothed_q.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: unexpected item x=%0d y=%0d last=%0b", $realtime,
						out_item.smooth_x, out_item.smooth_y, out_item.is_last);
			end else begin
				want = smoothed_q.pop_front();
				if (out_item.smooth_x !== want.smooth_x || out_item.smooth_y !== want.smooth_y ||
						out_item.is_last !== want.is_last) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
							$realtime, want.smooth_x, want.smooth_y, want.is_last,
							out_item.smooth_x, out_item.smooth_y, out_item.is_last);
				end
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer points
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_points.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				in_item <= pending_points.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Pace the receiver; hold it off once for a long stretch
	always @(negedge clk) begin
		if (stall_req && !stall_done) begin
			hold_left = STALL_CYCLES;
			stall_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || $urandom_range(99) >= IDLE_PCT;
		end
	end

	function automatic tsm_pkg::coord_t rand_coord();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return '0;
		else if (pick < 30)
			return COORD_MAX;
		return tsm_pkg::coord_t'($urandom_range(COORD_MAX));
	endfunction

	task automatic add_point(input tsm_pkg::coord_t x, input tsm_pkg::coord_t y,
			input logic last);
		tsm_pkg::in_item_t pt;
		pt.point_x = x;
		pt.point_y = y;
		pt.set_end = last;
		pending_points = {pending_points, pt};
	endtask

	// Wait until every point is taken and every smoothed point has come back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_points.size() != 0 || in_valid || smoothed_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write the half width while the block is idle
	task automatic set_half(input int unsigned h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= h[2:0];
		win_half = h;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Queue random sets: mostly full windows, some short sets, last one maybe left open
	task automatic add_random_sets(input int unsigned h);
		int unsigned added, len, i;
		bit leave_open;
		added = 0;
		while (added < PHASE_ITEMS) begin
			if (h != 0 && $urandom_range(99) < 15)
				len = $urandom_range(1, 2 * h);
			else
				len = $urandom_range(2 * h + 1, 2 * h + 10);
			leave_open = (added + len >= PHASE_ITEMS) && $urandom_range(99) < 40;
			for (i = 0; i < len; i++)
				add_point(rand_coord(), rand_coord(), i == len - 1 && !leave_open);
			added += len;
		end
	endtask

	initial begin
		int unsigned half_plan[10];
		int unsigned p, i;
		half_plan = '{3, 0, 7, 1, 5, 2, 6, 4, 7, 1};
		for (i = 0; i < HIST_DEPTH; i++) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset half width: extremes, one full set, two short sets
		add_point('0, '0, 1'b0);
		add_point(COORD_MAX, COORD_MAX, 1'b0);
		add_point(COORD_MAX, '0, 1'b1);
		add_point(10'd5, 10'd5, 1'b1);
		add_point(10'd1, 10'd2, 1'b0);
		add_point(10'd3, 10'd4, 1'b1);
		drain();

		// Zero half width passes points through
		set_half(0);
		add_point(COORD_MAX, '0, 1'b0);
		add_point('0, COORD_MAX, 1'b1);
		drain();

		// Widest window at full scale
		set_half(7);
		for (i = 0; i < 15; i++)
			add_point(COORD_MAX, COORD_MAX, i == 14);
		drain();

		// Random phases; open sets carry over into the next half width
		for (p = 0; p < 10; p++) begin
			set_half(half_plan[p]);
			steady = (p == 5);
			if (p == 3)
				stall_req = 1'b1;
			add_random_sets(half_plan[p]);
			drain();
			steady = 1'b0;
		end

		if (smoothed_q.size() != 0)
			bad_count++;
		if (bad_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
